[rtl/core/owtr_pkg.sv]
`timescale 1ns / 1ps

package owtr_pkg;

	// Tick counter width of the bus timing engine.
	localparam int COUNTER_WIDTH = 16;
	// Compare width for the phase-length test: holds count + 1 and a 16-bit length.
	localparam int CMP_W = (COUNTER_WIDTH + 1 > 17) ? COUNTER_WIDTH + 1 : 17;

	// Depth of the queue between front and back, and of the result queue.
	localparam int Q_DEPTH = 2;
	localparam int PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W   = $clog2(Q_DEPTH + 1);

	// Fixed bus timing.
	localparam logic [15:0] GAP_TICKS = 16'd10;
	localparam logic [15:0] ONE_TICK  = 16'd1;

	// Operation codes.
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_RESET = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_TEMP  = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] REG_PRESENCE_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_RESET_LOW_TICKS  = 2'd1;
	localparam logic [1:0] REG_SLOT_TICKS       = 2'd2;

	// ROM command bytes.
	localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
	localparam logic [7:0] CMD_CONVERT  = 8'h44;
	localparam logic [7:0] CMD_READ_SCR = 8'hBE;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_R_REL  = 4'd1,
		PH_R_LOW  = 4'd2,
		PH_R_GAP  = 4'd3,
		PH_R_WAIT = 4'd4,
		PH_R_POST = 4'd5,
		PH_S_REL  = 4'd6,
		PH_S_LOW  = 4'd7,
		PH_S_DATA = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		KIND_RESET = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] write_data;
		logic       bus_level;
	} in_item_t;

	typedef struct packed {
		logic              drive_low;
		logic              busy_res;
		logic              done_res;
		logic [7:0]        read_data;
		logic signed [15:0] temperature;
		logic              presence_seen;
	} out_item_t;

	// Item after classification by the front.
	typedef struct packed {
		logic       is_cmd;
		logic [2:0] op;
		logic [7:0] wdata;
		logic       bus;
	} tick_item_t;

	typedef struct packed {
		logic [15:0] presence_timeout;
		logic [9:0]  reset_low_ticks;
		logic [7:0]  slot_ticks;
	} cfg_t;

	// Temperature read sequence: unit kind per step.
	function automatic kind_t seq_kind(input logic [2:0] step);
		kind_t k;
		case (step)
			3'd0, 3'd3: k = KIND_RESET;
			3'd6, 3'd7: k = KIND_READ;
			default:    k = KIND_WRITE;
		endcase
		return k;
	endfunction

	// Temperature read sequence: byte sent per step.
	function automatic logic [7:0] seq_byte(input logic [2:0] step);
		logic [7:0] b;
		case (step)
			3'd1, 3'd4: b = CMD_SKIP_ROM;
			3'd2:       b = CMD_CONVERT;
			3'd5:       b = CMD_READ_SCR;
			default:    b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[rtl/core/owtr_front.sv]
`timescale 1ns / 1ps

module owtr_front import owtr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  in_item_t   command,
	output logic       item_valid,
	input  logic       item_pop,
	output tick_item_t item
);

	tick_item_t           mem_q [Q_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 wr_en;
	logic                 rd_en;
	tick_item_t           cls;

	// Codes five to seven act as a plain tick.
	always_comb begin
		cls.is_cmd = (command.operation == OP_RESET) || (command.operation == OP_WRITE) ||
			(command.operation == OP_READ) || (command.operation == OP_TEMP);
		cls.op     = command.operation;
		cls.wdata  = command.write_data;
		cls.bus    = command.bus_level;
	end

	assign full       = (cnt_q == CNT_W'(Q_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/owtr_back.sv]
`timescale 1ns / 1ps

module owtr_back import owtr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       item_valid,
	output logic       item_pop,
	input  tick_item_t item,
	output logic       empty,
	input  logic       pop,
	output out_item_t  result
);

	typedef struct packed {
		phase_t                   ph;
		logic [COUNTER_WIDTH-1:0] tc;
		logic [2:0]               bi;
		logic [7:0]               sb;
		logic [3:0]               step;
		logic [7:0]               lbh;
		logic [15:0]              th;
		logic                     pf;
		logic [2:0]               ac;
		logic [7:0]               lr;
	} eng_t;

	eng_t              st_q;
	eng_t              st_d;
	out_item_t         res;
	logic              eng_fire;
	logic              out_pop;
	out_item_t         out_mem_q [Q_DEPTH];
	logic [PTR_W-1:0]  out_wr_q;
	logic [PTR_W-1:0]  out_rd_q;
	logic [CNT_W-1:0]  out_cnt_q;

	function automatic kind_t unit_kind(input logic [2:0] ac, input logic [3:0] step);
		kind_t k;
		case (ac)
			OP_RESET: k = KIND_RESET;
			OP_WRITE: k = KIND_WRITE;
			OP_READ:  k = KIND_READ;
			default:  k = seq_kind(step[2:0]);
		endcase
		return k;
	endfunction

	// Phase ends on this tick; a saturated counter also ends it.
	function automatic logic run_out(input logic [COUNTER_WIDTH-1:0] tc,
		input logic [15:0] limit);
		logic [CMP_W-1:0] nxt;
		nxt = CMP_W'(tc) + CMP_W'(1);
		return (nxt >= CMP_W'(limit)) || (tc == '1);
	endfunction

	function automatic eng_t start_unit(input eng_t s, input logic [7:0] byte_in);
		eng_t r;
		r    = s;
		r.tc = '0;
		r.bi = '0;
		if (unit_kind(s.ac, s.step) == KIND_RESET) begin
			r.ph = PH_R_REL;
		end else begin
			r.ph = PH_S_REL;
			r.sb = byte_in;
		end
		return r;
	endfunction

	function automatic eng_t end_unit(input eng_t s);
		eng_t r;
		r = s;
		if (unit_kind(s.ac, s.step) == KIND_READ) begin
			r.lr = s.sb;
			if (s.ac == OP_TEMP) begin
				if (s.step[2:0] == 3'd6) begin
					r.lbh = s.sb;
				end else begin
					r.th = {s.sb, s.lbh};
				end
			end
		end
		if (s.ac == OP_TEMP && s.step < 4'd7) begin
			r.step = s.step + 4'd1;
			r      = start_unit(r, seq_byte(r.step[2:0]));
		end else begin
			r.ph = PH_IDLE;
			r.tc = '0;
		end
		return r;
	endfunction

	assign out_pop  = pop && !empty;
	assign eng_fire = item_valid && ((out_cnt_q != CNT_W'(Q_DEPTH)) || out_pop);
	assign item_pop = eng_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{ph: PH_IDLE, default: '0};
		end else if (eng_fire) begin
			st_q <= st_d;
		end
	end

	// One bus tick.
	always_comb begin
		logic  busy;
		logic  drive;
		logic  rd;
		logic  ends;
		eng_t  s;
		s     = st_q;
		busy  = 1'b0;
		drive = 1'b0;
		rd    = 1'b0;
		ends  = 1'b0;
		if (s.ph == PH_IDLE && item.is_cmd) begin
			s.ac   = item.op;
			s.step = '0;
			s      = start_unit(s, (item.op == OP_WRITE) ? item.wdata : seq_byte(3'd0));
		end
		if (s.ph != PH_IDLE) begin
			busy = 1'b1;
			case (s.ph)
				PH_R_REL: ends = run_out(s.tc, ONE_TICK);
				PH_R_LOW: begin
					drive = 1'b1;
					ends  = run_out(s.tc, {6'd0, cfg.reset_low_ticks});
				end
				PH_R_GAP:  ends = run_out(s.tc, GAP_TICKS);
				PH_R_WAIT: ends = !item.bus || run_out(s.tc, cfg.presence_timeout);
				PH_R_POST: ends = run_out(s.tc, {6'd0, cfg.reset_low_ticks});
				PH_S_REL:  ends = run_out(s.tc, ONE_TICK);
				PH_S_LOW: begin
					drive = 1'b1;
					ends  = run_out(s.tc, ONE_TICK);
				end
				default: begin
					rd = (unit_kind(s.ac, s.step) == KIND_READ);
					if (!rd && !s.sb[0]) begin
						drive = 1'b1;
					end
					if (rd && s.tc == '0) begin
						s.sb = {item.bus, s.sb[7:1]};
					end
					ends = run_out(s.tc, {8'd0, cfg.slot_ticks});
				end
			endcase
			s.tc = ends ? '0 : s.tc + 1'b1;
			if (ends) begin
				case (s.ph)
					PH_R_REL: s.ph = PH_R_LOW;
					PH_R_LOW: s.ph = PH_R_GAP;
					PH_R_GAP: s.ph = PH_R_WAIT;
					PH_R_WAIT: begin
						s.pf = !item.bus;
						s.ph = PH_R_POST;
					end
					PH_R_POST: s = end_unit(s);
					PH_S_REL:  s.ph = PH_S_LOW;
					PH_S_LOW:  s.ph = PH_S_DATA;
					default: begin
						if (!rd) begin
							s.sb = {1'b0, s.sb[7:1]};
						end
						if (s.bi == 3'd7) begin
							s = end_unit(s);
						end else begin
							s.bi = s.bi + 3'd1;
							s.ph = PH_S_REL;
						end
					end
				endcase
			end
		end
		st_d              = s;
		res.drive_low     = drive;
		res.busy_res      = busy;
		res.done_res      = busy && (s.ph == PH_IDLE);
		res.read_data     = s.lr;
		res.temperature   = $signed(s.th);
		res.presence_seen = s.pf;
	end

	// Result queue.
	assign empty  = (out_cnt_q == '0);
	assign result = out_mem_q[out_rd_q];

	always_ff @(posedge clk) begin
		if (eng_fire) begin
			out_mem_q[out_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (eng_fire) begin
				out_wr_q <= (out_wr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : out_wr_q + 1'b1;
			end
			if (out_pop) begin
				out_rd_q <= (out_rd_q == PTR_W'(Q_DEPTH - 1)) ? '0 : out_rd_q + 1'b1;
			end
			if (eng_fire && !out_pop) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (out_pop && !eng_fire) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= CNT_W'(Q_DEPTH))
		else $error("result queue overfilled");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		eng_fire && res.done_res |-> res.busy_res)
		else $error("done without busy");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		eng_fire && st_q.ph == PH_IDLE && !item.is_cmd |-> !res.busy_res && !res.drive_low)
		else $error("idle tick reports activity");

	a_fire_fill: assert property (@(posedge clk) disable iff (!arst_n)
		eng_fire |=> !empty)
		else $error("processed tick lost");

endmodule

[rtl/core/one_wire_temperature_read_master.sv]
// A tick beat accepted into the front queue is run by the back engine, which writes its
// result beat into the result queue; the engine stalls while that queue is full and not popped.
// Throughput: one tick beat per cycle unless stalled; the engine runs one bus tick per cycle.
// A 2-entry queue sits between classifier and engine, and a 2-entry result queue at the output.
// Reset (arst_n low, asynchronous): engine zeroed, queues empty, registers 1000 / 300 / 25.
// No clearing pass: the block takes beats right after reset.
`timescale 1ns / 1ps

module one_wire_temperature_read_master import owtr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// tick / command beats
	input  logic        push,
	output logic        full,
	input  in_item_t    command,
	// result beats
	output logic        empty,
	input  logic        pop,
	output out_item_t   result,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t       cfg_q;
	logic       cfg_wr;
	logic [1:0] reg_idx;
	logic       item_valid;
	logic       item_pop;
	tick_item_t item;

	// Registers sit at byte addresses 0, 4, 8.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.presence_timeout <= 16'd1000;
			cfg_q.reset_low_ticks  <= 10'd300;
			cfg_q.slot_ticks       <= 8'd25;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PRESENCE_TIMEOUT: cfg_q.presence_timeout <= pwdata[15:0];
				REG_RESET_LOW_TICKS:  cfg_q.reset_low_ticks  <= pwdata[9:0];
				REG_SLOT_TICKS:       cfg_q.slot_ticks       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read-back; unmapped addresses read zero.
	always_comb begin
		case (reg_idx)
			REG_PRESENCE_TIMEOUT: prdata = {16'd0, cfg_q.presence_timeout};
			REG_RESET_LOW_TICKS:  prdata = {22'd0, cfg_q.reset_low_ticks};
			REG_SLOT_TICKS:       prdata = {24'd0, cfg_q.slot_ticks};
			default:              prdata = 32'd0;
		endcase
	end

	// Front: accepts beats, flags real commands, buffers all beats.
	owtr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (item)
	);

	// Back: bus timing engine and result queue.
	owtr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule
